// ----- rtl/sn2d_pkg.sv -----
package sn2d_pkg;

   // Fixed-point format of the input point.
   localparam int FRAC_BITS = 16;

   // Permutation table geometry.
   localparam int PERM_SIZE = 256;
   localparam int PERM_AW   = $clog2(PERM_SIZE);

   // Width of a cell index: what is left of a 64-bit skewed value above its fraction.
   localparam int CELL_W = 34 - FRAC_BITS;

   // Corner offsets are Q.30 and stay well inside +/-8.
   localparam int OFS_W = 34;
   // Squares and falloff terms, Q.30, non-negative.
   localparam int SQ_W  = 30;
   // Gradient dot product where the falloff is live (|d| < 2.0).
   localparam int DOT_W = 32;
   // Fourth power of the falloff (at most 2^-4 in Q.30).
   localparam int T4_W  = 27;
   // One corner's contribution, Q.30.
   localparam int CON_W = 30;

   // Skew and unskew factors in Q0.30.
   localparam logic signed [30:0] F2_Q30 = 31'sd393016785;
   localparam logic signed [30:0] G2_Q30 = 31'sd226908346;

   // One half in Q.30.
   localparam logic signed [31:0] HALF_Q30 = 32'sh2000_0000;

   typedef logic signed [OFS_W-1:0] ofs_type;

   // Control that travels with each pipeline stage.
   typedef struct packed {
      logic vld;
      logic eval;
   } stg_type;

   // Hash value reduced mod 12, by multiplication with a reciprocal.
   function automatic logic [3:0] mod12(input logic [7:0] h);
      logic [15:0] p;
      logic [4:0]  q;
      logic [7:0]  r;
      p = {8'd0, h} * 16'd171;
      q = p[15:11];
      r = h - ({q, 3'd0} + {1'b0, q, 2'd0});
      return r[3:0];
   endfunction

   // X component of the gradient for index g.
   function automatic logic signed [1:0] grad_x(input logic [3:0] g);
      logic signed [1:0] v;
      case (g)
         4'd0, 4'd2, 4'd4, 4'd6: v = 2'sd1;
         4'd1, 4'd3, 4'd5, 4'd7: v = -2'sd1;
         default:                v = 2'sd0;
      endcase
      return v;
   endfunction

   // Y component of the gradient for index g.
   function automatic logic signed [1:0] grad_y(input logic [3:0] g);
      logic signed [1:0] v;
      case (g)
         4'd0, 4'd1, 4'd8, 4'd10: v = 2'sd1;
         4'd2, 4'd3, 4'd9, 4'd11: v = -2'sd1;
         default:                 v = 2'sd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/sn2d_ram.sv -----
module sn2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; the read holds while disabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sn2d_corner.sv -----
module sn2d_corner (
   input  logic                              clock,
   input  logic                              en,
   input  sn2d_pkg::ofs_type                 dx,
   input  sn2d_pkg::ofs_type                 dy,
   input  logic [7:0]                        hash,
   output logic signed [sn2d_pkg::CON_W-1:0] contrib
);

   // Stage A: squares of the offsets.
   sn2d_pkg::ofs_type             a_dx_ff, a_dy_ff;
   logic [sn2d_pkg::SQ_W-1:0]     a_sqx_ff, a_sqx_in, a_sqy_ff, a_sqy_in;
   logic                          a_big_ff, a_big_in;
   logic [sn2d_pkg::OFS_W-1:0]    magx, magy;
   logic [2*sn2d_pkg::SQ_W-1:0]   prodx, prody;

   // Stage B: falloff squared and gradient dot product.
   logic [sn2d_pkg::SQ_W-1:0]         b_t2_ff, b_t2_in;
   logic signed [sn2d_pkg::DOT_W-1:0] b_dot_ff, b_dot_in;
   logic                              b_neg_ff, b_neg_in;
   logic signed [31:0]                t_w;
   logic [2*sn2d_pkg::SQ_W-1:0]       tt;
   logic [3:0]                        g;
   logic signed [1:0]                 gx, gy;
   logic signed [sn2d_pkg::OFS_W:0]   px, py, dsum;

   // Stage C: fourth power of the falloff.
   logic [sn2d_pkg::T4_W-1:0]         c_t4_ff, c_t4_in;
   logic signed [sn2d_pkg::DOT_W-1:0] c_dot_ff;
   logic                              c_neg_ff;
   logic [2*sn2d_pkg::SQ_W-1:0]       t2sq;

   // Stage D: the weighted contribution.
   logic signed [sn2d_pkg::CON_W-1:0]               d_con_ff, d_con_in;
   logic signed [sn2d_pkg::T4_W+sn2d_pkg::DOT_W:0]  wprod;

   // Magnitudes; an offset of one or more always kills the falloff.
   assign magx     = dx[sn2d_pkg::OFS_W-1] ? -dx : dx;
   assign magy     = dy[sn2d_pkg::OFS_W-1] ? -dy : dy;
   assign a_big_in = (|magx[sn2d_pkg::OFS_W-1:30]) | (|magy[sn2d_pkg::OFS_W-1:30]);
   assign prodx    = magx[29:0] * magx[29:0];
   assign prody    = magy[29:0] * magy[29:0];
   assign a_sqx_in = prodx[59:30];
   assign a_sqy_in = prody[59:30];

   // Falloff term and its square.
   assign t_w      = sn2d_pkg::HALF_Q30 - $signed({2'b00, a_sqx_ff})
                     - $signed({2'b00, a_sqy_ff});
   assign b_neg_in = a_big_ff | t_w[31];
   assign tt       = t_w[29:0] * t_w[29:0];
   assign b_t2_in  = tt[59:30];

   // Gradient selection and dot product with unit components.
   assign g  = sn2d_pkg::mod12(hash);
   assign gx = sn2d_pkg::grad_x(g);
   assign gy = sn2d_pkg::grad_y(g);

   always_comb begin
      px = '0;
      py = '0;
      if (gx == 2'sd1) begin
         px = {a_dx_ff[sn2d_pkg::OFS_W-1], a_dx_ff};
      end else if (gx == -2'sd1) begin
         px = -{a_dx_ff[sn2d_pkg::OFS_W-1], a_dx_ff};
      end
      if (gy == 2'sd1) begin
         py = {a_dy_ff[sn2d_pkg::OFS_W-1], a_dy_ff};
      end else if (gy == -2'sd1) begin
         py = -{a_dy_ff[sn2d_pkg::OFS_W-1], a_dy_ff};
      end
   end

   assign dsum     = px + py;
   assign b_dot_in = dsum[sn2d_pkg::DOT_W-1:0];

   // Fourth power.
   assign t2sq    = b_t2_ff * b_t2_ff;
   assign c_t4_in = t2sq[56:30];

   // Contribution, floored back to Q.30; a dead corner gives zero.
   assign wprod    = $signed({1'b0, c_t4_ff}) * c_dot_ff;
   assign d_con_in = c_neg_ff ? '0 : wprod[59:30];

   always_ff @(posedge clock) begin
      if (en) begin
         a_dx_ff  <= dx;
         a_dy_ff  <= dy;
         a_sqx_ff <= a_sqx_in;
         a_sqy_ff <= a_sqy_in;
         a_big_ff <= a_big_in;
         b_t2_ff  <= b_t2_in;
         b_dot_ff <= b_dot_in;
         b_neg_ff <= b_neg_in;
         c_t4_ff  <= c_t4_in;
         c_dot_ff <= b_dot_ff;
         c_neg_ff <= b_neg_ff;
         d_con_ff <= d_con_in;
      end
   end

   assign contrib = d_con_ff;

endmodule

// ----- rtl/simplex_noise_2d_unit.sv -----
// Channel  Direction  Fields (lowest bit first)
// req      in         tuser: func; tdata: x_coord, y_coord, perm_index, perm_value
// rsp      out        tdata: noise_value
//
// The pipeline has eight register stages; one item enters per cycle unless the result
// register is stalled, and an evaluate transfer raises rsp_tvalid when it reaches the
// stage 8 result register. Load transfers give no result.
// The stage count is set by the multiplier chain of each corner (square, falloff
// squared, fourth power, weighting) after the skew and unskew products.
// Reset clears the stage valid bits only; the permutation table is not cleared.
// A stalled result register freezes every stage, so nothing is lost or repeated.
module simplex_noise_2d_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // x_coord[31:0], y_coord[63:32], perm_index, perm_value
   input  logic        req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // noise_value
);

   localparam int AW = sn2d_pkg::PERM_AW;
   localparam int CW = sn2d_pkg::CELL_W;

   logic en;

   // Stage control.
   sn2d_pkg::stg_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff, s7_ff;
   sn2d_pkg::stg_type s1_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]       rsp_tdata_ff, rsp_tdata_in;

   // Stage 1: skew product.
   logic signed [31:0] s1_x_ff, s1_y_ff;
   logic signed [62:0] s1_sk_ff, s1_sk_in;
   logic [AW-1:0]      s1_idx_ff, s1_val_ff;
   logic signed [32:0] pt_sum;
   logic signed [63:0] sk_prod;

   // Stage 2: cell indices.
   logic signed [31:0]   s2_x_ff, s2_y_ff;
   logic signed [CW-1:0] s2_i_ff, s2_i_in, s2_j_ff, s2_j_in;
   logic [AW-1:0]        s2_idx_ff, s2_val_ff;
   logic signed [63:0]   xs, ys;

   // Stage 3: first corner offsets.
   sn2d_pkg::ofs_type  s3_x0_ff, s3_x0_in, s3_y0_ff, s3_y0_in;
   logic [AW-1:0]      s3_ii_ff, s3_pj0_ff, s3_pj1_ff;
   logic [AW-1:0]      s3_idx_ff, s3_val_ff;
   logic signed [CW:0]    ij;
   logic signed [CW+30:0] ij_g2;
   logic signed [63:0]    xd, yd, x0f, y0f;

   // Stage 4 inputs: triangle order, other offsets, hashed addresses.
   logic              i1;
   sn2d_pkg::ofs_type x1, y1, x2, y2;
   logic [AW-1:0]     ha0, ha1, ha2;

   // Table copies: two read the cell row, three read the corner hashes.
   logic          wr_a, wr_b;
   logic [AW-1:0] ra_addr [2];
   logic [AW-1:0] ra_data [2];
   logic [AW-1:0] rb_addr [3];
   logic [AW-1:0] rb_data [3];

   // Corner contributions at stage 7.
   logic signed [sn2d_pkg::CON_W-1:0] con [3];

   // Final sum and scaling.
   logic signed [31:0] tot;
   logic signed [38:0] scaled;
   logic signed [23:0] r_full;

   // The whole pipeline moves unless the result register holds an untaken transfer.
   assign en         = ~rsp_tvalid_ff | rsp_tready;
   assign req_tready = en;

   assign s1_in.vld  = req_tvalid;
   assign s1_in.eval = req_tuser;

   // Stage 1: sum of coordinates times F2.
   assign pt_sum   = {req_tdata[31], req_tdata[31:0]} + {req_tdata[63], req_tdata[63:32]};
   assign sk_prod  = pt_sum * sn2d_pkg::F2_Q30;
   assign s1_sk_in = sk_prod[62:0];

   // Stage 2: skewed coordinates floored to cell indices.
   assign xs = {{2{s1_x_ff[31]}}, s1_x_ff, 30'd0} + {s1_sk_ff[62], s1_sk_ff};
   assign ys = {{2{s1_y_ff[31]}}, s1_y_ff, 30'd0} + {s1_sk_ff[62], s1_sk_ff};
   assign s2_i_in = xs[63:sn2d_pkg::FRAC_BITS+30];
   assign s2_j_in = ys[63:sn2d_pkg::FRAC_BITS+30];

   // Row lookups for the cell's j and j+1; table copies A take loads at stage 1.
   assign wr_a       = en & s1_ff.vld & ~s1_ff.eval;
   assign ra_addr[0] = s2_j_in[AW-1:0];
   assign ra_addr[1] = s2_j_in[AW-1:0] + 1'b1;

   // Stage 3: unskewed offset of the first corner, exact in Q.30.
   assign ij    = {s2_i_ff[CW-1], s2_i_ff} + {s2_j_ff[CW-1], s2_j_ff};
   assign ij_g2 = ij * sn2d_pkg::G2_Q30;
   assign xd    = {{32{s2_x_ff[31]}}, s2_x_ff}
                  - ({{(64-CW){s2_i_ff[CW-1]}}, s2_i_ff} <<< sn2d_pkg::FRAC_BITS);
   assign yd    = {{32{s2_y_ff[31]}}, s2_y_ff}
                  - ({{(64-CW){s2_j_ff[CW-1]}}, s2_j_ff} <<< sn2d_pkg::FRAC_BITS);
   assign x0f   = (xd <<< (30 - sn2d_pkg::FRAC_BITS))
                  + {{(63-CW-30){ij_g2[CW+30]}}, ij_g2};
   assign y0f   = (yd <<< (30 - sn2d_pkg::FRAC_BITS))
                  + {{(63-CW-30){ij_g2[CW+30]}}, ij_g2};
   assign s3_x0_in = x0f[sn2d_pkg::OFS_W-1:0];
   assign s3_y0_in = y0f[sn2d_pkg::OFS_W-1:0];

   // Stage 4 inputs: equal offsets step in y first.
   assign i1 = s3_x0_ff > s3_y0_ff;
   assign x1 = s3_x0_ff - (i1 ? sn2d_pkg::ofs_type'(1 <<< 30) : '0)
               + sn2d_pkg::ofs_type'(sn2d_pkg::G2_Q30);
   assign y1 = s3_y0_ff - (i1 ? '0 : sn2d_pkg::ofs_type'(1 <<< 30))
               + sn2d_pkg::ofs_type'(sn2d_pkg::G2_Q30);
   assign x2 = s3_x0_ff - sn2d_pkg::ofs_type'(1 <<< 30)
               + (sn2d_pkg::ofs_type'(sn2d_pkg::G2_Q30) <<< 1);
   assign y2 = s3_y0_ff - sn2d_pkg::ofs_type'(1 <<< 30)
               + (sn2d_pkg::ofs_type'(sn2d_pkg::G2_Q30) <<< 1);

   // Corner hash addresses; table copies B take loads at stage 3.
   assign ha0 = s3_ii_ff + s3_pj0_ff;
   assign ha1 = s3_ii_ff + AW'(i1) + (i1 ? s3_pj0_ff : s3_pj1_ff);
   assign ha2 = s3_ii_ff + 1'b1 + s3_pj1_ff;
   assign wr_b       = en & s3_ff.vld & ~s3_ff.eval;
   assign rb_addr[0] = ha0;
   assign rb_addr[1] = ha1;
   assign rb_addr[2] = ha2;

   for (genvar k = 0; k < 2; k++) begin : g_ram_a
      sn2d_ram #(
         .WIDTH (AW),
         .DEPTH (sn2d_pkg::PERM_SIZE)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_a),
         .wr_addr (s1_idx_ff),
         .wr_data (s1_val_ff),
         .rd_en   (en),
         .rd_addr (ra_addr[k]),
         .rd_data (ra_data[k])
      );
   end

   for (genvar k = 0; k < 3; k++) begin : g_ram_b
      sn2d_ram #(
         .WIDTH (AW),
         .DEPTH (sn2d_pkg::PERM_SIZE)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_b),
         .wr_addr (s3_idx_ff),
         .wr_data (s3_val_ff),
         .rd_en   (en),
         .rd_addr (rb_addr[k]),
         .rd_data (rb_data[k])
      );
   end

   // Corner datapaths, stages 4 to 7.
   sn2d_corner u_corner0 (
      .clock   (clock),
      .en      (en),
      .dx      (s3_x0_ff),
      .dy      (s3_y0_ff),
      .hash    (rb_data[0]),
      .contrib (con[0])
   );

   sn2d_corner u_corner1 (
      .clock   (clock),
      .en      (en),
      .dx      (x1),
      .dy      (y1),
      .hash    (rb_data[1]),
      .contrib (con[1])
   );

   sn2d_corner u_corner2 (
      .clock   (clock),
      .en      (en),
      .dx      (x2),
      .dy      (y2),
      .hash    (rb_data[2]),
      .contrib (con[2])
   );

   // Stage 8: sum times 70, floored to Q.15 and saturated.
   assign tot    = 32'(con[0]) + 32'(con[1]) + 32'(con[2]);
   assign scaled = (39'(tot) <<< 6) + (39'(tot) <<< 2) + (39'(tot) <<< 1);
   assign r_full = scaled[38:15];

   always_comb begin
      if (r_full > 24'sd32767) begin
         rsp_tdata_in = 16'h7fff;
      end else if (r_full < -24'sd32768) begin
         rsp_tdata_in = 16'h8000;
      end else begin
         rsp_tdata_in = r_full[15:0];
      end
   end

   assign rsp_tvalid_in = s7_ff.vld & s7_ff.eval;

   // Stage control with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff         <= '0;
         s2_ff         <= '0;
         s3_ff         <= '0;
         s4_ff         <= '0;
         s5_ff         <= '0;
         s6_ff         <= '0;
         s7_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         s1_ff         <= s1_in;
         s2_ff         <= s1_ff;
         s3_ff         <= s2_ff;
         s4_ff         <= s3_ff;
         s5_ff         <= s4_ff;
         s6_ff         <= s5_ff;
         s7_ff         <= s6_ff;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff      <= req_tdata[31:0];
         s1_y_ff      <= req_tdata[63:32];
         s1_sk_ff     <= s1_sk_in;
         s1_idx_ff    <= req_tdata[71:64];
         s1_val_ff    <= req_tdata[79:72];
         s2_x_ff      <= s1_x_ff;
         s2_y_ff      <= s1_y_ff;
         s2_i_ff      <= s2_i_in;
         s2_j_ff      <= s2_j_in;
         s2_idx_ff    <= s1_idx_ff;
         s2_val_ff    <= s1_val_ff;
         s3_x0_ff     <= s3_x0_in;
         s3_y0_ff     <= s3_y0_in;
         s3_ii_ff     <= s2_i_ff[AW-1:0];
         s3_pj0_ff    <= ra_data[0];
         s3_pj1_ff    <= ra_data[1];
         s3_idx_ff    <= s2_idx_ff;
         s3_val_ff    <= s2_val_ff;
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ----- verif/simplex_noise_2d_unit_test.sv -----
module simplex_noise_2d_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint SKEW_Q30   = 64'sd393016785;
   localparam longint UNSKEW_Q30 = 64'sd226908346;
   localparam longint ONE_Q30    = 64'sd1 << 30;
   localparam longint HALF_Q30L  = 64'sd1 << 29;
   localparam int     STALL_LIMIT = 5000;
   localparam int     HOLD_CYCLES = 300;

   typedef enum logic { OP_LOAD = 1'b0, OP_EVAL = 1'b1 } op_type;

   typedef struct {
      op_type           op;
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
      logic [7:0]       perm_index;
      logic [7:0]       perm_value;
   } noise_req_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;

   noise_req_type      pending_reqs[$];
   logic signed [15:0] noise_expected[$];
   logic [7:0]         perm_shadow[sn2d_pkg::PERM_SIZE];

   int  send_idle_pct;
   int  recv_stall_pct;
   bit  holdoff_request;
   int  holdoff_count;
   int  error_count;
   int  eval_count;
   int  load_count;
   int  quiet_cycles;

   simplex_noise_2d_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Free-running clock, 20 ns period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // One corner's falloff-weighted gradient contribution, Q.30.
   function automatic longint corner_share(input longint dx, input longint dy,
                                           input int grad);
      longint falloff, f2, f4, dot;
      int     gx, gy;
      falloff = HALF_Q30L - ((dx * dx) >>> 30) - ((dy * dy) >>> 30);
      if (falloff < 0) return 0;
      f2 = (falloff * falloff) >>> 30;
      f4 = (f2 * f2) >>> 30;
      gx = (grad < 8) ? (grad[0] ? -1 : 1) : 0;
      gy = (grad < 4) ? (grad[1] ? -1 : 1) : ((grad < 8) ? 0 : (grad[0] ? -1 : 1));
      dot = gx * dx + gy * dy;
      return (f4 * dot) >>> 30;
   endfunction

   // Noise value at a Q16.16 point, using the shadow permutation table.
   function automatic logic signed [15:0] noise_at(input logic signed [31:0] px,
                                                   input logic signed [31:0] py);
      longint x, y, sk, ci, cj, x0, y0, x1, y1, x2, y2, total, scaled;
      int     step_i, step_j, gi0, gi1, gi2;
      logic [7:0] ii, jj;
      x = px;
      y = py;
      sk = (x + y) * SKEW_Q30;
      ci = (x * ONE_Q30 + sk) >>> (sn2d_pkg::FRAC_BITS + 30);
      cj = (y * ONE_Q30 + sk) >>> (sn2d_pkg::FRAC_BITS + 30);
      x0 = (x - (ci <<< sn2d_pkg::FRAC_BITS)) * (64'sd1 << (30 - sn2d_pkg::FRAC_BITS))
           + (ci + cj) * UNSKEW_Q30;
      y0 = (y - (cj <<< sn2d_pkg::FRAC_BITS)) * (64'sd1 << (30 - sn2d_pkg::FRAC_BITS))
           + (ci + cj) * UNSKEW_Q30;
      // Equal offsets take the upper triangle.
      step_i = (x0 > y0) ? 1 : 0;
      step_j = 1 - step_i;
      x1 = x0 - step_i * ONE_Q30 + UNSKEW_Q30;
      y1 = y0 - step_j * ONE_Q30 + UNSKEW_Q30;
      x2 = x0 - ONE_Q30 + 2 * UNSKEW_Q30;
      y2 = y0 - ONE_Q30 + 2 * UNSKEW_Q30;
      ii = ci[7:0];
      jj = cj[7:0];
      gi0 = perm_shadow[8'(ii + perm_shadow[jj])] % 12;
      gi1 = perm_shadow[8'(ii + step_i + perm_shadow[8'(jj + step_j)])] % 12;
      gi2 = perm_shadow[8'(ii + 1 + perm_shadow[8'(jj + 1)])] % 12;
      total = corner_share(x0, y0, gi0) + corner_share(x1, y1, gi1)
            + corner_share(x2, y2, gi2);
      scaled = (total * 70) >>> 15;
      if (scaled > 32767) scaled = 32767;
      if (scaled < -32768) scaled = -32768;
      return scaled[15:0];
   endfunction

   // Driver: offers queued items, idling at the current rate.
   always @(posedge clock) begin
      noise_req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
      end else begin
         // Prediction happens on the accepted transfer, in order.
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_EVAL) begin
               noise_expected = {noise_expected,
                                 noise_at(req_tdata[31:0], req_tdata[63:32])};
               eval_count++;
            end else begin
               perm_shadow[req_tdata[71:64]] = req_tdata[79:72];
               load_count++;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               item = pending_reqs.pop_front();
               req_tdata  <= {item.perm_value, item.perm_index, item.y_coord, item.x_coord};
               req_tuser  <= item.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls plus an occasional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready    <= 1'b0;
         holdoff_count <= 0;
      end else if (holdoff_request && holdoff_count < HOLD_CYCLES) begin
         rsp_tready    <= 1'b0;
         holdoff_count <= holdoff_count + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         if (!holdoff_request) holdoff_count <= 0;
      end
   end

   // Monitor: each result transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      logic signed [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (noise_expected.size() == 0) begin
            $error("noise_value: unexpected result %0d", $signed(rsp_tdata));
            error_count++;
         end else begin
            want = noise_expected.pop_front();
            if (rsp_tdata !== want) begin
               $error("noise_value: expected %0d, actual %0d", want, $signed(rsp_tdata));
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_load(input logic [7:0] idx, input logic [7:0] val);
      noise_req_type item;
      item.op = OP_LOAD;
      item.x_coord = $urandom;
      item.y_coord = $urandom;
      item.perm_index = idx;
      item.perm_value = val;
      pending_reqs = {pending_reqs, item};
   endtask

   task automatic queue_eval(input logic signed [31:0] px, input logic signed [31:0] py);
      noise_req_type item;
      item.op = OP_EVAL;
      item.x_coord = px;
      item.y_coord = py;
      item.perm_index = 8'($urandom);
      item.perm_value = 8'($urandom);
      pending_reqs = {pending_reqs, item};
   endtask

   // Fill random traffic: mostly evaluations, some table reloads.
   task automatic queue_random(input int count);
      int sel;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(99);
         if (sel < 12)
            queue_load(8'($urandom), 8'($urandom));
         else if (sel < 40)
            queue_eval($urandom, $urandom);
         else
            queue_eval($signed(32'($urandom_range(0, 2097151))) - 32'sd1048576,
                       $signed(32'($urandom_range(0, 2097151))) - 32'sd1048576);
      end
   endtask

   // Wait until nothing is queued, offered or expected.
   task automatic drain_all;
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || noise_expected.size() != 0);
      @(posedge clock);
   endtask

   initial begin
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      holdoff_request = 1'b0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Every table entry is written before any evaluation reads it.
      for (int k = 0; k < sn2d_pkg::PERM_SIZE; k++) queue_load(8'(k), 8'($urandom));
      queue_load(8'd0, 8'd255);
      queue_load(8'd255, 8'd0);
      // Directed points: extremes, origin, equal offsets, cell wrap.
      queue_eval(32'sh7fff_ffff, 32'sh7fff_ffff);
      queue_eval(-32'sh8000_0000, -32'sh8000_0000);
      queue_eval(32'sh7fff_ffff, -32'sh8000_0000);
      queue_eval(-32'sh8000_0000, 32'sh7fff_ffff);
      queue_eval(32'sd0, 32'sd0);
      queue_eval(32'sh0000_8000, 32'sh0000_8000);
      queue_eval(-32'sh0000_4000, -32'sh0000_4000);
      queue_eval(32'sh00ff_8000, 32'sh0000_2000);
      queue_eval(32'sh0100_0000, -32'sh0100_0000);
      queue_eval(32'sh0000_3000, 32'sh0000_c000);
      queue_eval(32'sh0000_c000, 32'sh0000_3000);
      queue_eval(-32'sd1, 32'sd1);
      drain_all();

      // Phase without idling, including a long receiver hold-off.
      queue_random(350);
      while (pending_reqs.size() >= 300) @(posedge clock);
      holdoff_request = 1'b1;
      while (holdoff_count < HOLD_CYCLES) @(posedge clock);
      holdoff_request = 1'b0;
      drain_all();

      // Sparse sender.
      send_idle_pct = 88;
      queue_random(350);
      drain_all();

      // Stalling receiver.
      send_idle_pct  = 0;
      recv_stall_pct = 88;
      queue_random(350);
      drain_all();

      // Light idling on both sides.
      send_idle_pct  = 10;
      recv_stall_pct = 10;
      queue_random(400);
      drain_all();
      repeat (20) @(posedge clock);

      $display("Covered %0d noise evaluations and %0d table loads over four idling phases.",
               eval_count, load_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/sn2d_pkg.sv
rtl/sn2d_ram.sv
rtl/sn2d_corner.sv
rtl/simplex_noise_2d_unit.sv
verif/simplex_noise_2d_unit_test.sv
